/* rtl/clcd_pkg.sv */
// Shared types and constants for the character LCD framer.
// No dependencies; imported by the framer top level.
package clcd_pkg;

    // Largest number of display rows the framer supports
    localparam int unsigned MAX_ROWS = 4;

    // Host operation codes
    localparam logic [1:0] FUNC_CHAR   = 2'd0;
    localparam logic [1:0] FUNC_CMD    = 2'd1;
    localparam logic [1:0] FUNC_SETCUR = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_COLUMNS  = 3'd0;
    localparam logic [2:0] CFG_ROWS     = 3'd1;
    localparam logic [2:0] CFG_WRAP     = 3'd2;
    localparam logic [2:0] CFG_ROW_OFF0 = 3'd3;
    localparam logic [2:0] CFG_ROW_OFF1 = 3'd4;
    localparam logic [2:0] CFG_ROW_OFF2 = 3'd5;
    localparam logic [2:0] CFG_ROW_OFF3 = 3'd6;

    // Display command bytes
    localparam logic [7:0] CMD_SET_ADDR = 8'h80;
    localparam logic [7:0] CMD_CLEAR    = 8'h01;
    localparam logic [7:0] CMD_HOME     = 8'h02;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_FIN,
        ST_EMIT
    } t_state;

endpackage

/* rtl/char_lcd_cursor_wrap_framer.sv */
// Character LCD framer: host operations in, register-select/value frames out.
// Depends on clcd_pkg (operation codes, register indexes, state type).
//
//  channel  | valid       | stall        | payload
//  ---------+-------------+--------------+-----------------------------------------
//  input    | i_in_valid  | o_in_stall   | i_func, i_payload, i_column, i_row
//  output   | o_out_valid | i_out_stall  | o_register_select, o_value, o_long_exec,
//           |             |              | o_last
//  config   | i_cfg_we    | (none)       | i_cfg_index, i_cfg_data
//
// Character, raw command and set cursor with wrap off are framed in the cycle the
// transaction is taken. A character that runs past the last column is followed by
// its set-address frame from ST_EMIT. Set cursor with wrap on runs a restoring
// divider over the eight column bits, one bit per cycle, then forms the address
// in ST_FIN; input stalls until its frame is out. The row offset adder is the
// one shared unit. Reset is synchronous, active low; no clearing pass is needed.
// A stall on the output holds the frame register and, through it, stalls the input side.
module char_lcd_cursor_wrap_framer
    import clcd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input channel
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_func,
    input  logic [7:0] i_payload,
    input  logic [7:0] i_column,
    input  logic [7:0] i_row,
    // output channel
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_register_select,
    output logic [7:0] o_value,
    output logic       o_long_exec,
    output logic       o_last,
    // configuration
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_index,
    input  logic [6:0] i_cfg_data
);

    // ---------------------------------------------------------------- registers
    t_state     r_state,   n_state;
    logic [6:0] r_columns;
    logic [2:0] r_rows;
    logic       r_wrap;
    logic [6:0] r_row_off [4];

    logic [7:0] r_cur_col, n_cur_col;
    logic [1:0] r_cur_row, n_cur_row;

    // divider state
    logic [7:0] r_rem,  n_rem;   // partial remainder, always below columns
    logic [7:0] r_num,  n_num;   // dividend bits still to shift in
    logic [1:0] r_qmod, n_qmod;  // quotient so far, mod effective rows
    logic [2:0] r_cnt,  n_cnt;
    logic [1:0] r_row,  n_row;   // clamped requested row

    // frame waiting behind the output register (always a set-address command)
    logic [7:0] r_pend, n_pend;

    // output frame register
    logic       r_out_valid, n_out_valid;
    logic       r_out_rs,    n_out_rs;
    logic [7:0] r_out_val,   n_out_val;
    logic       r_out_lx,    n_out_lx;
    logic       r_out_last,  n_out_last;

    // -------------------------------------------------------- derived config
    logic [6:0] eff_cols;
    logic [2:0] eff_rows;

    always_comb begin
        eff_cols = (r_columns == 7'd0) ? 7'd1 : r_columns;
        if (r_rows == 3'd0) begin
            eff_rows = 3'd1;
        end else if (r_rows > 3'(MAX_ROWS)) begin
            eff_rows = 3'(MAX_ROWS);
        end else begin
            eff_rows = r_rows;
        end
    end

    // ------------------------------------------------------------ datapath
    logic       out_free;
    logic       in_accept;
    logic [1:0] row_cl;
    logic [7:0] inc_col;
    logic [1:0] inc_row;
    logic       col_over;
    logic [7:0] trial;
    logic       trial_ge;
    logic [2:0] qm_t;
    logic [2:0] row_sum;
    logic [1:0] fin_row;
    logic [1:0] off_idx;
    logic [6:0] off_rd;
    logic [6:0] addr_col;
    logic [6:0] addr_sum;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != ST_IDLE) || !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_comb begin
        // requested row clamped to the rows in use
        row_cl  = (i_row >= {5'd0, eff_rows}) ? 2'(eff_rows - 3'd1) : i_row[1:0];

        // cursor advance for a character write
        inc_col  = r_cur_col + 8'd1;
        col_over = (inc_col >= {1'b0, eff_cols});
        inc_row  = r_cur_row + 2'd1;
        if ({1'b0, inc_row} >= eff_rows) begin
            inc_row = 2'd0;
        end

        // restoring divider step, one column bit per cycle
        trial    = {r_rem[6:0], r_num[7]};
        trial_ge = (trial >= {1'b0, eff_cols});

        // running quotient mod rows: doubling plus one bit stays below 2 * rows
        qm_t = {r_qmod, trial_ge};
        if (qm_t >= eff_rows) begin
            qm_t = qm_t - eff_rows;
        end

        // final row: clamped row plus folded rows, again below 2 * rows
        row_sum = {1'b0, r_row} + {1'b0, r_qmod};
        if (row_sum >= eff_rows) begin
            row_sum = row_sum - eff_rows;
        end
        fin_row = row_sum[1:0];

        // single read port on the row offset registers
        if (r_state == ST_FIN) begin
            off_idx  = fin_row;
            addr_col = r_rem[6:0];
        end else if (i_func == FUNC_CHAR) begin
            off_idx  = inc_row;
            addr_col = 7'd0;
        end else begin
            off_idx  = row_cl;
            addr_col = i_column[6:0];
        end
        off_rd   = r_row_off[off_idx];
        addr_sum = addr_col + off_rd;
    end

    // ---------------------------------------------- sequencer, next state
    always_comb begin
        n_state     = r_state;
        n_cur_col   = r_cur_col;
        n_cur_row   = r_cur_row;
        n_rem       = r_rem;
        n_num       = r_num;
        n_qmod      = r_qmod;
        n_cnt       = r_cnt;
        n_row       = r_row;
        n_pend      = r_pend;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_rs    = r_out_rs;
        n_out_val   = r_out_val;
        n_out_lx    = r_out_lx;
        n_out_last  = r_out_last;

        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    priority if (i_func == FUNC_CHAR) begin
                        n_out_valid = 1'b1;
                        n_out_rs    = 1'b1;
                        n_out_val   = i_payload;
                        n_out_lx    = 1'b0;
                        n_out_last  = 1'b1;
                        if (r_wrap) begin
                            n_cur_col = inc_col;
                            if (col_over) begin
                                // past the last column: queue set-address to next row
                                n_cur_col  = 8'd0;
                                n_cur_row  = inc_row;
                                n_out_last = 1'b0;
                                n_pend     = CMD_SET_ADDR | {1'b0, addr_sum};
                                n_state    = ST_EMIT;
                            end
                        end
                    end else if (i_func == FUNC_CMD) begin
                        n_out_valid = 1'b1;
                        n_out_rs    = 1'b0;
                        n_out_val   = i_payload;
                        n_out_last  = 1'b1;
                        n_out_lx    = 1'b0;
                        if (i_payload == CMD_CLEAR || i_payload == CMD_HOME) begin
                            n_cur_col = 8'd0;
                            n_cur_row = 2'd0;
                            n_out_lx  = 1'b1;
                        end
                    end else if (i_func == FUNC_SETCUR) begin
                        if (r_wrap) begin
                            n_rem   = 8'd0;
                            n_num   = i_column;
                            n_qmod  = 2'd0;
                            n_cnt   = 3'd0;
                            n_row   = row_cl;
                            n_state = ST_DIV;
                        end else begin
                            n_out_valid = 1'b1;
                            n_out_rs    = 1'b0;
                            n_out_val   = CMD_SET_ADDR | {1'b0, addr_sum};
                            n_out_lx    = 1'b0;
                            n_out_last  = 1'b1;
                        end
                    end else begin
                        // unused operation code: dropped without a frame
                    end
                end
            end
            ST_DIV: begin
                n_rem  = trial_ge ? (trial - {1'b0, eff_cols}) : trial;
                n_num  = {r_num[6:0], 1'b0};
                n_qmod = qm_t[1:0];
                n_cnt  = r_cnt + 3'd1;
                if (r_cnt == 3'd7) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                n_cur_col = r_rem;
                n_cur_row = fin_row;
                n_pend    = CMD_SET_ADDR | {1'b0, addr_sum};
                n_state   = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_rs    = 1'b0;
                    n_out_val   = r_pend;
                    n_out_lx    = 1'b0;
                    n_out_last  = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------ control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_out_valid  <= 1'b0;
            r_cur_col    <= 8'd0;
            r_cur_row    <= 2'd0;
            r_cnt        <= 3'd0;
            r_columns    <= 7'd20;
            r_rows       <= 3'd4;
            r_wrap       <= 1'b1;
            r_row_off[0] <= 7'd0;
            r_row_off[1] <= 7'd64;
            r_row_off[2] <= 7'd20;
            r_row_off[3] <= 7'd84;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_cur_col   <= n_cur_col;
            r_cur_row   <= n_cur_row;
            r_cnt       <= n_cnt;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_COLUMNS:  r_columns    <= i_cfg_data;
                    CFG_ROWS:     r_rows       <= i_cfg_data[2:0];
                    CFG_WRAP:     r_wrap       <= i_cfg_data[0];
                    CFG_ROW_OFF0: r_row_off[0] <= i_cfg_data;
                    CFG_ROW_OFF1: r_row_off[1] <= i_cfg_data;
                    CFG_ROW_OFF2: r_row_off[2] <= i_cfg_data;
                    CFG_ROW_OFF3: r_row_off[3] <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // ------------------------------------------------------ payload registers
    always_ff @(posedge i_clk) begin
        r_rem      <= n_rem;
        r_num      <= n_num;
        r_qmod     <= n_qmod;
        r_row      <= n_row;
        r_pend     <= n_pend;
        r_out_rs   <= n_out_rs;
        r_out_val  <= n_out_val;
        r_out_lx   <= n_out_lx;
        r_out_last <= n_out_last;
    end

    assign o_out_valid       = r_out_valid;
    assign o_register_select = r_out_rs;
    assign o_value           = r_out_val;
    assign o_long_exec       = r_out_lx;
    assign o_last            = r_out_last;

    // -------------------------------------------------------------- assertions
`ifndef SYNTHESIS
    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> o_in_stall)
        else $error("input taken while sequencer busy");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_rem < {1'b0, eff_cols}))
        else $error("divider remainder not below columns");

    a_qmod_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> ({1'b0, r_qmod} < eff_rows))
        else $error("folded row count not below rows");

    a_clear_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_func == FUNC_CMD
            && (i_payload == CMD_CLEAR || i_payload == CMD_HOME))
        |=> (r_cur_col == 8'd0 && r_cur_row == 2'd0 && o_long_exec))
        else $error("clear or home did not zero cursor");
`endif

endmodule
